// ----- rtl/core/psf_pkg.sv -----
// shared types, constants, program table and helpers of the piezo speaker filter
package psf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 24;
  localparam int DIFF_W   = 26;
  localparam int COEF_W   = 17;
  localparam int PROD_W   = DIFF_W + COEF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int GAIN_W   = ACC_W + 3;
  localparam int STEP_W   = 4;
  localparam int NSTAGE   = 3;
  localparam int FRAC_SH  = 16;
  localparam int LP_KEEP_SH = 12;

  localparam logic signed [COEF_W-1:0] HP_COEF = 17'sd40960;
  localparam logic signed [COEF_W-1:0] LP_TAKE = 17'sd61439;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = -16'sd32768;
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sd32767;

  // micro-operation codes
  localparam logic [2:0] OP_WAIT   = 3'd0;
  localparam logic [2:0] OP_HP_MUL = 3'd1;
  localparam logic [2:0] OP_HP_WB  = 3'd2;
  localparam logic [2:0] OP_GAIN   = 3'd3;
  localparam logic [2:0] OP_LP_MUL = 3'd4;
  localparam logic [2:0] OP_LP_WB  = 3'd5;
  localparam logic [2:0] OP_EMIT   = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] idx;
    logic       wrap;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } status_t;

  function automatic ctrl_t mk(input logic [2:0] op, input logic [1:0] idx, input logic wrap);
    ctrl_t c;
    c.op = op;
    c.idx = idx;
    c.wrap = wrap;
    return c;
  endfunction

  // program: load, three high-pass stages, x4 gain, three low-pass stages, x2 and emit
  function automatic ctrl_t prog_rom(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      4'd0:    c = mk(OP_WAIT,   2'd0, 1'b0);
      4'd1:    c = mk(OP_HP_MUL, 2'd0, 1'b0);
      4'd2:    c = mk(OP_HP_WB,  2'd0, 1'b0);
      4'd3:    c = mk(OP_HP_MUL, 2'd1, 1'b0);
      4'd4:    c = mk(OP_HP_WB,  2'd1, 1'b0);
      4'd5:    c = mk(OP_HP_MUL, 2'd2, 1'b0);
      4'd6:    c = mk(OP_HP_WB,  2'd2, 1'b0);
      4'd7:    c = mk(OP_GAIN,   2'd0, 1'b0);
      4'd8:    c = mk(OP_LP_MUL, 2'd0, 1'b0);
      4'd9:    c = mk(OP_LP_WB,  2'd0, 1'b0);
      4'd10:   c = mk(OP_LP_MUL, 2'd1, 1'b0);
      4'd11:   c = mk(OP_LP_WB,  2'd1, 1'b0);
      4'd12:   c = mk(OP_LP_MUL, 2'd2, 1'b0);
      4'd13:   c = mk(OP_LP_WB,  2'd2, 1'b0);
      4'd14:   c = mk(OP_EMIT,   2'd0, 1'b1);
      default: c = mk(OP_WAIT,   2'd0, 1'b1);
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [GAIN_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v < S16_MIN) begin
      r = S16_MIN;
    end else if (v > S16_MAX) begin
      r = S16_MAX;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/psf_seq.sv -----
// step counter and program table of the piezo speaker filter
module psf_seq
  import psf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              hold;

  assign ctrl = prog_rom(step);

  // the load (wait) step holds until an input word is valid, the emit step until the output register is free
  assign hold = ((ctrl.op == OP_WAIT) && !status.in_valid) ||
                ((ctrl.op == OP_EMIT) && !status.out_free);

  always_comb begin
    if (hold) begin
      step_next = step;
    end else if (ctrl.wrap) begin
      step_next = '0;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- rtl/core/psf_datapath.sv -----
// shared multiplier, accumulator, filter history and output register
module psf_datapath
  import psf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  output status_t             status,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata
);

  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prev;
  logic signed [SAMPLE_W-1:0] hp_prev_input;
  logic signed [ACC_W-1:0]    hp_out [NSTAGE];
  logic signed [SAMPLE_W-1:0] lp_out [NSTAGE];
  logic signed [PROD_W-1:0]   prod;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [DIFF_W-1:0]   mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [ACC_W-1:0]    hp_y;
  logic signed [SUM_W-1:0]    lp_sum;
  logic signed [SAMPLE_W-1:0] lp_y;
  logic                       out_free;
  logic                       in_acc;

  assign s_tready = (ctrl.op == OP_WAIT);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign status.in_valid = s_tvalid;
  assign status.out_free = out_free;

  assign diff  = DIFF_W'(acc) + DIFF_W'(hp_out[ctrl.idx]) - DIFF_W'(prev);
  assign mul_a = (ctrl.op == OP_HP_MUL) ? diff : DIFF_W'(acc);
  assign mul_b = (ctrl.op == OP_HP_MUL) ? HP_COEF : LP_TAKE;

  // flooring shifts
  assign hp_y   = ACC_W'(prod >>> FRAC_SH);
  assign lp_sum = SUM_W'(prod) + (SUM_W'(lp_out[ctrl.idx]) <<< LP_KEEP_SH);
  assign lp_y   = SAMPLE_W'(lp_sum >>> FRAC_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_prev_input <= '0;
      for (int i = 0; i < NSTAGE; i++) begin
        hp_out[i] <= '0;
        lp_out[i] <= '0;
      end
      m_tvalid <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_WAIT: begin
          if (in_acc) begin
            acc           <= ACC_W'($signed(s_tdata));
            prev          <= ACC_W'(hp_prev_input);
            hp_prev_input <= $signed(s_tdata);
          end
        end
        OP_HP_MUL, OP_LP_MUL: begin
          prod <= mul_a * mul_b;
        end
        OP_HP_WB: begin
          prev            <= hp_out[ctrl.idx];
          hp_out[ctrl.idx] <= hp_y;
          acc             <= hp_y;
        end
        OP_GAIN: begin
          acc <= ACC_W'(sat16(GAIN_W'(acc) <<< 2));
        end
        OP_LP_WB: begin
          lp_out[ctrl.idx] <= lp_y;
          acc             <= ACC_W'(lp_y);
        end
        OP_EMIT: begin
          if (out_free) begin
            m_tdata <= sat16(GAIN_W'(acc) <<< 1);
          end
        end
        default: begin
        end
      endcase
      if ((ctrl.op == OP_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/piezo_speaker_filter.sv -----
// top level of the piezo speaker filter
//
// one signed 16-bit sample word in on the s_ channel, one filtered signed
// 16-bit sample word out on the m_ channel, both with a tvalid/tready
// handshake
// the sample passes three first-order high-pass stages, a x4 gain with
// saturation, three first-order low-pass stages and a x2 gain with
// saturation
// a small program in a table steps one shared multiplier through the
// filter: load, two steps per stage (multiply, shift and write back), one
// gain step, one emit step
// a new input word is taken only after the program has run all its steps for
// the last one: the six multiplies and their write-backs on the single
// multiplier plus the load, gain and emit steps
// s_tready is high only while the program waits at its load step
// a stalled receiver holds the result in the output register; the next input
// word is still taken and worked, and the program waits at its emit step
// until the output register is free
// reset clears the step counter, the filter history and the output valid
module piezo_speaker_filter
  import psf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata    // [15:0] sample_out
);

  ctrl_t   ctrl;
  status_t status;

  // program sequencer
  psf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // datapath driven by the current control word
  psf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- rtl/core/psf_checker.sv -----
// port checks of the piezo speaker filter, bound to the top level
module psf_checker
  import psf_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [SAMPLE_W-1:0] s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [SAMPLE_W-1:0] m_tdata
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  // after reset the block waits for input with no result pending
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("bad state after reset");

  // one word at a time: no new input right after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input taken while busy");

  // a result appears only at the end of the program, not while loading
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without work");

  logic unused_ok;
  assign unused_ok = ^s_tdata;

endmodule

bind piezo_speaker_filter psf_checker u_psf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- verif/tb.sv -----
// self-checking testbench of the piezo speaker filter with a bit-true filter scoreboard
import psf_pkg::*;

// keeps the filter history and the queue of filtered words still to come out
class filter_scoreboard;
  localparam longint HP_COEF_Q16 = 40960;
  localparam longint LP_HOLD_Q16 = 4096;
  localparam longint LP_PASS_Q16 = 65535 - 4096;

  logic signed [SAMPLE_W-1:0] hp_last_in;
  logic signed [23:0]         hp_y [3];
  logic signed [SAMPLE_W-1:0] lp_y [3];
  logic signed [SAMPLE_W-1:0] filtered_q [$];
  int taken;
  int checked;
  int mismatches;
  int railed;

  function new();
    hp_last_in = '0;
    foreach (hp_y[i]) hp_y[i] = '0;
    foreach (lp_y[i]) lp_y[i] = '0;
    taken = 0;
    checked = 0;
    mismatches = 0;
    railed = 0;
  endfunction

  function longint clamp_s16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // runs one sample through the six stages and queues the word the block owes
  function void note_sample(logic [SAMPLE_W-1:0] raw);
    longint x;
    longint stage_in;
    longint prev_in;
    longint y;
    longint v;
    x = longint'($signed(raw));
    stage_in = x;
    prev_in = longint'(hp_last_in);
    for (int i = 0; i < 3; i++) begin
      // >>> on a signed longint floors toward minus infinity
      y = (HP_COEF_Q16 * (stage_in + longint'(hp_y[i]) - prev_in)) >>> 16;
      prev_in = longint'(hp_y[i]);
      hp_y[i] = y[23:0];
      stage_in = y;
    end
    hp_last_in = raw;
    v = clamp_s16(stage_in * 4);
    for (int i = 0; i < 3; i++) begin
      y = (longint'(lp_y[i]) * LP_HOLD_Q16 + v * LP_PASS_Q16) >>> 16;
      lp_y[i] = y[SAMPLE_W-1:0];
      v = y;
    end
    v = clamp_s16(v * 2);
    filtered_q.push_back(v[SAMPLE_W-1:0]);
    taken++;
  endfunction

  function void check_word(logic [SAMPLE_W-1:0] got);
    logic signed [SAMPLE_W-1:0] want;
    if (filtered_q.size() == 0) begin
      mismatches++;
      $display("%0t: sample_out %0d with no sample owed", $time, $signed(got));
      return;
    end
    want = filtered_q.pop_front();
    checked++;
    if (want == 16'sh7fff || want == -16'sh8000) railed++;
    if (got !== want) begin
      mismatches++;
      $display("%0t: sample_out mismatch, expected %0d, actual %0d",
               $time, want, $signed(got));
    end
  endfunction
endclass

module tb;
  localparam int N_RANDOM    = 1200;
  localparam int STUCK_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 40;

  typedef enum {WAVE_NOISE, WAVE_RAILS, WAVE_QUIET, WAVE_STEP} wave_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [SAMPLE_W-1:0] m_tdata;

  filter_scoreboard sb;
  bit calm;
  int stuck_cycles;

  logic [SAMPLE_W-1:0] warmup_words [20] = '{
    16'h0000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
    16'h7fff, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 16'h5555,
    16'haaaa, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000
  };

  piezo_speaker_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short pauses, now and then a long one, none while calm
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // presents one sample word and returns at the falling edge after it is taken
  task automatic send_sample(input logic [SAMPLE_W-1:0] word);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = word;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // receiver back-pressure
  initial begin
    int rx_left;
    m_tready = 1'b0;
    rx_left = 0;
    forever begin
      @(negedge clk);
      if (calm) begin
        m_tready = 1'b1;
        rx_left = 0;
      end else if (rx_left > 0) begin
        rx_left--;
      end else begin
        m_tready = ~m_tready;
        rx_left = m_tready ? $urandom_range(0, 20) : pause_len();
      end
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_sample(s_tdata);
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        sb.check_word(m_tdata);
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    wave_t style;
    int seg_left;
    int half;
    int k;
    int tmp;
    logic [SAMPLE_W-1:0] level;
    logic [SAMPLE_W-1:0] word;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    stuck_cycles = 0;
    sb = new();
    seg_left = 0;
    half = 1;
    k = 0;
    level = '0;
    style = WAVE_NOISE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // rails, hard swings between them, tiny values and alternating bits
    foreach (warmup_words[i]) send_sample(warmup_words[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        tmp = $urandom_range(0, 9);
        style = (tmp < 4) ? WAVE_NOISE : (tmp < 6) ? WAVE_RAILS :
                (tmp < 8) ? WAVE_QUIET : WAVE_STEP;
        half = $urandom_range(1, 6);
        level = SAMPLE_W'($urandom);
        k = 0;
      end
      case (style)
        WAVE_NOISE: word = SAMPLE_W'($urandom);
        WAVE_RAILS: word = ((k / half) % 2) ? 16'h8000 : 16'h7fff;
        WAVE_QUIET: begin
          tmp = $urandom_range(0, 1023) - 512;
          word = tmp[SAMPLE_W-1:0];
        end
        default:    word = level;
      endcase
      send_sample(word);
      seg_left--;
      k++;
    end
    s_tvalid = 1'b0;
    calm = 1'b0;

    while (sb.filtered_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("fed %0d samples (directed extremes, noise, rail square waves, small", sb.taken);
    $display("signals, steps); %0d filtered words checked, %0d at the rails, %0d mismatches",
             sb.checked, sb.railed, sb.mismatches);
    if (sb.mismatches == 0 && sb.filtered_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
